/* rtl/core/baro_pressure_temp_compensation_assert.svh */
// assertion helpers for the rtl
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// condition must hold at every clock outside reset
`define BPT_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define BPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/bpt_pkg.sv */
`default_nettype none
package bpt_pkg;

   localparam int DIV_BITS = 32;

   typedef enum logic [1:0] {
      CSR_COEFF_A,
      CSR_COEFF_B,
      CSR_COEFF_C,
      CSR_OVERSAMPLING
   } bpt_csr_type;

   // unpacked calibration set, raw 16-bit coefficient fields and the 2-bit oss
   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] mc;
      logic [15:0] md;
      logic [1:0]  oss;
   } bpt_coeff_type;

   // what the front hands to the back through the queue
   typedef struct packed {
      logic [31:0] x1;
      logic [23:0] up;
   } bpt_item_type;

   localparam logic [31:0] B6_OFFSET  = 32'd4000;
   localparam logic [31:0] K_SQUARE   = 32'd3038;
   localparam logic [31:0] K_LINEAR   = 32'hFFFF_E343; // -7357
   localparam logic [31:0] K_OFFSET   = 32'd3791;
   localparam logic [31:0] K_B7_SCALE = 32'd50000;
   localparam logic [31:0] K_B4_BIAS  = 32'd32768;
   localparam logic [31:0] SIGN_BIT32 = 32'h8000_0000;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] sh);
      return $unsigned($signed(v) >>> sh);
   endfunction

   function automatic logic [15:0] sat_temp(input logic [31:0] v);
      logic [15:0] r;
      if ($signed(v) > $signed(32'sd32767)) r = 16'h7FFF;
      else if ($signed(v) < $signed(-32'sd32768)) r = 16'h8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic [20:0] sat_press(input logic [31:0] v);
      logic [20:0] r;
      if ($signed(v) > $signed(32'sd1048575)) r = 21'h0F_FFFF;
      else if ($signed(v) < $signed(-32'sd1048576)) r = 21'h10_0000;
      else r = v[20:0];
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/bpt_front.sv */
`default_nettype none
module bpt_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bpt_pkg::bpt_coeff_type coeff,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [15:0]           req_raw_temperature,
   input  wire logic [23:0]           req_raw_pressure_bytes,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output bpt_pkg::bpt_item_type      push_item
);
   import bpt_pkg::*;

   logic         valid_ff, valid_in;
   bpt_item_type item_ff, item_in;
   logic [31:0]  diff;
   logic [31:0]  prod;
   logic         take;

   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      diff       = {16'd0, req_raw_temperature} - {16'd0, coeff.ac6};
      prod       = diff * {16'd0, coeff.ac5};
      item_in.x1 = asr32(prod, 5'd15);
      item_in.up = req_raw_pressure_bytes >> (4'd8 - {2'b00, coeff.oss});
      valid_in   = take || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/bpt_queue.sv */
`default_nettype none
module bpt_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire bpt_pkg::bpt_item_type push_item,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output bpt_pkg::bpt_item_type     pop_item
);
   import bpt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   bpt_item_type     mem [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != FULL;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

`include "baro_pressure_temp_compensation_assert.svh"
   `BPT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL)
   `BPT_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `BPT_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)
endmodule
`default_nettype wire

/* rtl/core/bpt_div.sv */
`default_nettype none
module bpt_div #(
   parameter int PAY_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [31:0]      in_num,
   input  wire logic [31:0]      in_den,
   input  wire logic [PAY_W-1:0] in_pay,
   output logic                  out_valid,
   output logic [31:0]           out_quo,
   output logic [PAY_W-1:0]      out_pay
);
   import bpt_pkg::*;

   logic [31:0]      rem_ff [0:DIV_BITS-1];
   logic [31:0]      nq_ff  [0:DIV_BITS-1];
   logic [31:0]      den_ff [0:DIV_BITS-1];
   logic [PAY_W-1:0] pay_ff [0:DIV_BITS-1];
   logic [DIV_BITS-1:0] vld_ff;

   // one quotient bit per stage, restoring
   for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
      logic [31:0]      rem_i, nq_i, den_i, rem_in, nq_in;
      logic [PAY_W-1:0] pay_i;
      logic             vld_i;
      logic [32:0]      shifted, trial;

      if (g == 0) begin : g_first
         assign rem_i = '0;
         assign nq_i  = in_num;
         assign den_i = in_den;
         assign pay_i = in_pay;
         assign vld_i = in_valid;
      end else begin : g_next
         assign rem_i = rem_ff[g-1];
         assign nq_i  = nq_ff[g-1];
         assign den_i = den_ff[g-1];
         assign pay_i = pay_ff[g-1];
         assign vld_i = vld_ff[g-1];
      end

      always_comb begin
         shifted = {rem_i, nq_i[31]};
         trial   = shifted - {1'b0, den_i};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            nq_in  = {nq_i[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            nq_in  = {nq_i[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            nq_ff[g]  <= nq_in;
            den_ff[g] <= den_i;
            pay_ff[g] <= pay_i;
         end
      end
   end

   assign out_valid = vld_ff[DIV_BITS-1];
   assign out_quo   = nq_ff[DIV_BITS-1];
   assign out_pay   = pay_ff[DIV_BITS-1];
endmodule
`default_nettype wire

/* rtl/core/bpt_back.sv */
`default_nettype none
module bpt_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bpt_pkg::bpt_coeff_type coeff,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire bpt_pkg::bpt_item_type  pop_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [15:0]         rsp_temperature_tenths,
   output logic signed [20:0]         rsp_pressure_pa,
   output logic                       rsp_divide_error
);
   import bpt_pkg::*;

   localparam int PAY1_W = 32 + 24 + 2;
   localparam int PAY2_W = 2 + 16;

   logic en;

   // ---- temperature divide setup
   logic [31:0] num1, den1, an1, ad1;
   logic        dz0, neg0;
   logic [PAY1_W-1:0] pay1_in, pay1_out;
   logic        d1_valid;
   logic [31:0] d1_quo;

   assign en        = !rsp_valid || rsp_ready;
   assign pop_ready = en;

   always_comb begin
      num1    = {{5{coeff.mc[15]}}, coeff.mc, 11'd0};
      den1    = pop_item.x1 + sext16(coeff.md);
      dz0     = den1 == '0;
      an1     = num1[31] ? -num1 : num1;
      ad1     = dz0 ? 32'd1 : (den1[31] ? -den1 : den1);
      neg0    = num1[31] ^ den1[31];
      pay1_in = {pop_item.x1, pop_item.up, dz0, neg0};
   end

   bpt_div #(.PAY_W(PAY1_W)) u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (pop_valid),
      .in_num   (an1),
      .in_den   (ad1),
      .in_pay   (pay1_in),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_pay  (pay1_out)
   );

   // ---- stage 1: b5, temperature, b6
   logic        v1_ff;
   logic [31:0] b6_1_ff, b6_1_in;
   logic [23:0] up1_ff;
   logic        dz1_ff;
   logic [15:0] t1_ff, t1_in;
   logic [31:0] x1_d, x2_d, b5;
   logic [23:0] up_d;
   logic        dz_d, neg_d;

   always_comb begin
      {x1_d, up_d, dz_d, neg_d} = pay1_out;
      x2_d    = neg_d ? -d1_quo : d1_quo;
      b5      = x1_d + x2_d;
      t1_in   = sat_temp(asr32(b5 + 32'd8, 5'd4));
      b6_1_in = b5 - B6_OFFSET;
   end

   // ---- stage 2: products with b6
   logic        v2_ff;
   logic [31:0] sqp2_ff, pa2_2_ff, pa3_2_ff;
   logic [23:0] up2_ff;
   logic        dz2_ff;
   logic [15:0] t2_ff;

   // ---- stage 3: products with sq
   logic        v3_ff;
   logic [31:0] mb2_3_ff, mb1_3_ff, x2a_3_ff, x1c_3_ff, sq3;
   logic [23:0] up3_ff;
   logic        dz3_ff;
   logic [15:0] t3_ff;

   // ---- stage 4: b3 and b4 operand
   logic        v4_ff;
   logic [31:0] b3_4_ff, t32_4_ff, x3_4, v_4, b3_4_in, x3p_4;
   logic [23:0] up4_ff;
   logic        dz4_ff;
   logic [15:0] t4_ff;

   // ---- stage 5: b4
   logic        v5_ff;
   logic [31:0] b4_5_ff, um_5_ff, b4p_5;
   logic        dz5_ff;
   logic [15:0] t5_ff;

   // ---- stage 6: b7
   logic        v6_ff;
   logic [31:0] b7_6_ff, b4_6_ff;
   logic        fail6_ff;
   logic [15:0] t6_ff;

   always_comb begin
      sq3    = asr32(sqp2_ff, 5'd12);
      x3_4   = asr32(mb2_3_ff, 5'd11) + x2a_3_ff;
      v_4    = (((sext16(coeff.ac1) << 2) + x3_4) << coeff.oss) + 32'd2;
      // signed divide by four truncates toward zero
      b3_4_in = asr32(v_4 + (v_4[31] ? 32'd3 : 32'd0), 5'd2);
      x3p_4  = asr32(asr32(mb1_3_ff, 5'd16) + x1c_3_ff + 32'd2, 5'd2);
      b4p_5  = {16'd0, coeff.ac4} * t32_4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= d1_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b6_1_ff  <= b6_1_in;
         up1_ff   <= up_d;
         dz1_ff   <= dz_d;
         t1_ff    <= t1_in;

         sqp2_ff  <= b6_1_ff * b6_1_ff;
         pa2_2_ff <= sext16(coeff.ac2) * b6_1_ff;
         pa3_2_ff <= sext16(coeff.ac3) * b6_1_ff;
         up2_ff   <= up1_ff;
         dz2_ff   <= dz1_ff;
         t2_ff    <= t1_ff;

         mb2_3_ff <= sext16(coeff.b2) * sq3;
         mb1_3_ff <= sext16(coeff.b1) * sq3;
         x2a_3_ff <= asr32(pa2_2_ff, 5'd11);
         x1c_3_ff <= asr32(pa3_2_ff, 5'd13);
         up3_ff   <= up2_ff;
         dz3_ff   <= dz2_ff;
         t3_ff    <= t2_ff;

         b3_4_ff  <= b3_4_in;
         t32_4_ff <= x3p_4 + K_B4_BIAS;
         up4_ff   <= up3_ff;
         dz4_ff   <= dz3_ff;
         t4_ff    <= t3_ff;

         b4_5_ff  <= b4p_5 >> 15;
         um_5_ff  <= {8'd0, up4_ff} - b3_4_ff;
         dz5_ff   <= dz4_ff;
         t5_ff    <= t4_ff;

         b7_6_ff  <= um_5_ff * (K_B7_SCALE >> coeff.oss);
         b4_6_ff  <= b4_5_ff;
         fail6_ff <= dz5_ff || (b4_5_ff == '0);
         t6_ff    <= t5_ff;
      end
   end

   // ---- pressure divide, unsigned
   logic [31:0] num2, den2;
   logic        big6;
   logic [PAY2_W-1:0] pay2_in, pay2_out;
   logic        d2_valid;
   logic [31:0] d2_quo;

   always_comb begin
      big6    = b7_6_ff >= SIGN_BIT32;
      num2    = big6 ? b7_6_ff : (b7_6_ff << 1);
      den2    = (b4_6_ff == '0) ? 32'd1 : b4_6_ff;
      pay2_in = {big6, fail6_ff, t6_ff};
   end

   bpt_div #(.PAY_W(PAY2_W)) u_div_press (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v6_ff),
      .in_num   (num2),
      .in_den   (den2),
      .in_pay   (pay2_in),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_pay  (pay2_out)
   );

   // ---- stage 7/8: pressure correction terms
   logic        v7_ff, v8_ff;
   logic [31:0] p7_ff, m1_7_ff, m2_7_ff, p7_in, pp7;
   logic [31:0] p8_ff, ma_8_ff, x2_8_ff;
   logic        fail7_ff, fail8_ff, big_d, fail_d;
   logic [15:0] t7_ff, t8_ff, t_d;

   always_comb begin
      {big_d, fail_d, t_d} = pay2_out;
      p7_in = big_d ? (d2_quo << 1) : d2_quo;
      pp7   = asr32(p7_in, 5'd8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= d2_valid;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p7_ff    <= p7_in;
         m1_7_ff  <= pp7 * pp7;
         m2_7_ff  <= K_LINEAR * p7_in;
         fail7_ff <= fail_d;
         t7_ff    <= t_d;

         p8_ff    <= p7_ff;
         ma_8_ff  <= m1_7_ff * K_SQUARE;
         x2_8_ff  <= asr32(m2_7_ff, 5'd16);
         fail8_ff <= fail7_ff;
         t8_ff    <= t7_ff;
      end
   end

   // ---- output register
   logic        rsp_valid_ff;
   logic [15:0] temp_ff, temp_in;
   logic [20:0] press_ff, press_in;
   logic        err_ff;
   logic [31:0] pf;

   always_comb begin
      pf = p8_ff + asr32(asr32(ma_8_ff, 5'd16) + x2_8_ff + K_OFFSET, 5'd4);
      if (fail8_ff) begin
         temp_in  = '0;
         press_in = '0;
      end else begin
         temp_in  = t8_ff;
         press_in = sat_press(pf);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         temp_ff  <= temp_in;
         press_ff <= press_in;
         err_ff   <= fail8_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_tenths = $signed(temp_ff);
   assign rsp_pressure_pa        = $signed(press_ff);
   assign rsp_divide_error       = err_ff;
endmodule
`default_nettype wire

/* rtl/core/baro_pressure_temp_compensation.sv */
`default_nettype none
// Integer barometric compensation: each request transaction carries a raw
// temperature word and raw pressure bytes and yields one response with the
// temperature in 0.1 degree units, the pressure in pascals (both saturated)
// and a divide error flag that zeroes both values. Throughput is one
// transaction per clock while the response side does not stall. From
// request accept to response valid a transaction passes one front register,
// the queue, two 32-stage pipelined dividers (one quotient bit per stage), the
// eight multiply stages around them and the output register. While the
// response side stalls, the front keeps taking requests until the queue is full.
// Calibration words and oversampling are written through the csr port and
// must be stable while transactions are in flight.
module baro_pressure_temp_compensation #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [15:0]        req_raw_temperature,
   input  wire logic [23:0]        req_raw_pressure_bytes,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_temperature_tenths,
   output logic signed [20:0]      rsp_pressure_pa,
   output logic                    rsp_divide_error,
   input  wire logic               csr_write_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);
   import bpt_pkg::*;

   logic [63:0]   coeff_a_ff, coeff_b_ff;
   logic [31:0]   coeff_c_ff;
   logic [1:0]    oss_ff;
   bpt_coeff_type coeff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff <= '0;
         coeff_b_ff <= '0;
         coeff_c_ff <= '0;
         oss_ff     <= 2'd2;
      end else if (csr_write_en) begin
         unique case (bpt_csr_type'(csr_index))
            CSR_COEFF_A:      coeff_a_ff <= csr_wdata;
            CSR_COEFF_B:      coeff_b_ff <= csr_wdata;
            CSR_COEFF_C:      coeff_c_ff <= csr_wdata[31:0];
            CSR_OVERSAMPLING: oss_ff     <= csr_wdata[1:0];
            default:          coeff_c_ff <= coeff_c_ff;
         endcase
      end
   end

   always_comb begin
      coeff.ac1 = coeff_a_ff[15:0];
      coeff.ac2 = coeff_a_ff[31:16];
      coeff.ac3 = coeff_a_ff[47:32];
      coeff.ac4 = coeff_a_ff[63:48];
      coeff.ac5 = coeff_b_ff[15:0];
      coeff.ac6 = coeff_b_ff[31:16];
      coeff.b1  = coeff_b_ff[47:32];
      coeff.b2  = coeff_b_ff[63:48];
      coeff.mc  = coeff_c_ff[15:0];
      coeff.md  = coeff_c_ff[31:16];
      coeff.oss = oss_ff;
   end

   logic         push_valid, push_ready, pop_valid, pop_ready;
   bpt_item_type push_item, pop_item;

   bpt_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .coeff                 (coeff),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_raw_temperature   (req_raw_temperature),
      .req_raw_pressure_bytes(req_raw_pressure_bytes),
      .push_valid            (push_valid),
      .push_ready            (push_ready),
      .push_item             (push_item)
   );

   bpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item (push_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item)
   );

   bpt_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .coeff                 (coeff),
      .pop_valid             (pop_valid),
      .pop_ready             (pop_ready),
      .pop_item              (pop_item),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature_tenths(rsp_temperature_tenths),
      .rsp_pressure_pa       (rsp_pressure_pa),
      .rsp_divide_error      (rsp_divide_error)
   );
endmodule
`default_nettype wire

/* verif/baro_pressure_temp_compensation_test.sv */
`default_nettype none
module baro_pressure_temp_compensation_test;
   import bpt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] temperature;
      logic signed [20:0] pressure;
      logic               div_err;
   } reading_type;

   typedef struct {
      bit          is_csr;
      bpt_csr_type idx;
      logic [63:0] wdata;
      logic [15:0] ut;
      logic [23:0] up;
      bit          typed;
      reading_type want;
   } stim_row_type;

   localparam reading_type DIV_FAULT = '{temperature: 16'sd0, pressure: 21'sd0, div_err: 1'b1};
   localparam logic [63:0] CAL_A = 64'h7FE5_C7D1_FFB8_0198;
   localparam logic [63:0] CAL_B = 64'h0004_182E_5A71_7FF5;
   localparam logic [63:0] CAL_C = 64'h0000_0000_0B34_DDF9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_raw_temperature = '0;
   logic [23:0] req_raw_pressure_bytes = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_temperature_tenths;
   logic signed [20:0] rsp_pressure_pa;
   logic rsp_divide_error;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // shadow copy of the calibration registers
   logic [63:0] cal_a = '0;
   logic [63:0] cal_b = '0;
   logic [31:0] cal_c = '0;
   logic [1:0]  cal_oss = 2'd2;

   reading_type pending_readings[$];
   int errors = 0;
   int send_idle_pct = 11;
   int recv_idle_pct = 52;
   int cycle_count = 0;
   int received = 0;
   int hold_cycles = 0;
   bit hold_done = 1'b0;

   baro_pressure_temp_compensation uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_raw_temperature(req_raw_temperature),
      .req_raw_pressure_bytes(req_raw_pressure_bytes),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_temperature_tenths(rsp_temperature_tenths),
      .rsp_pressure_pa(rsp_pressure_pa),
      .rsp_divide_error(rsp_divide_error),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sra(input logic [31:0] v, input int n);
      logic signed [31:0] s;
      s = $signed(v) >>> n;
      return s;
   endfunction

   function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
      longint q;
      q = longint'($signed(a)) / longint'($signed(b));
      return q[31:0];
   endfunction

   function automatic reading_type compensate(input logic [15:0] ut_raw,
                                              input logic [23:0] up_raw);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, prod;
      longint t, pr;
      reading_type r;
      ac1 = sx16(cal_a[15:0]);   ac2 = sx16(cal_a[31:16]);
      ac3 = sx16(cal_a[47:32]);  ac4 = {16'd0, cal_a[63:48]};
      ac5 = {16'd0, cal_b[15:0]}; ac6 = {16'd0, cal_b[31:16]};
      b1 = sx16(cal_b[47:32]);   b2 = sx16(cal_b[63:48]);
      mc = sx16(cal_c[15:0]);    md = sx16(cal_c[31:16]);
      ut = {16'd0, ut_raw};
      up = {8'd0, up_raw} >> (8 - int'(cal_oss));

      prod = (ut - ac6) * ac5;
      x1 = sra(prod, 15);
      den = x1 + md;
      if (den == 0) return DIV_FAULT;
      x2 = sdiv(mc << 11, den);
      b5 = x1 + x2;
      t = longint'($signed(sra(b5 + 32'd8, 4)));

      b6 = b5 - 32'd4000;
      prod = b6 * b6;
      sq = sra(prod, 12);
      prod = b2 * sq;
      x1 = sra(prod, 11);
      prod = ac2 * b6;
      x2 = sra(prod, 11);
      x3 = x1 + x2;
      prod = ac1 * 32'd4 + x3;
      b3 = sdiv((prod << cal_oss) + 32'd2, 32'd4);

      prod = ac3 * b6;
      x1 = sra(prod, 13);
      prod = b1 * sq;
      x2 = sra(prod, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      prod = ac4 * (x3 + 32'd32768);
      b4 = prod >> 15;
      if (b4 == 0) return DIV_FAULT;

      b7 = (up - b3) * (32'd50000 >> cal_oss);
      if (b7 < 32'h8000_0000) begin
         prod = b7 * 32'd2;
         p = prod / b4;
      end else begin
         prod = b7 / b4;
         p = prod * 32'd2;
      end

      prod = sra(p, 8) * sra(p, 8);
      prod = prod * 32'd3038;
      x1 = sra(prod, 16);
      prod = 32'hFFFF_E343 * p;
      x2 = sra(prod, 16);
      p = p + sra(x1 + x2 + 32'd3791, 4);
      pr = longint'($signed(p));

      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (pr > 1048575) pr = 1048575;
      if (pr < -1048576) pr = -1048576;
      r.temperature = t[15:0];
      r.pressure = pr[20:0];
      r.div_err = 1'b0;
      return r;
   endfunction

   // registers change only with nothing in flight
   task automatic write_csr(input bpt_csr_type idx, input logic [63:0] data);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_COEFF_A:     cal_a = data;
         CSR_COEFF_B:     cal_b = data;
         CSR_COEFF_C:     cal_c = data[31:0];
         CSR_OVERSAMPLING: cal_oss = data[1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [15:0] ut, input logic [23:0] up,
                              input bit typed, input reading_type want);
      // each idle cycle is drawn on its own
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_temperature <= ut;
      req_raw_pressure_bytes <= up;
      pending_readings.push_back(typed ? want : compensate(ut, up));
      do @(posedge clock); while (!req_ready);
   endtask

   // response side: checks and random back pressure, with one long hold-off
   always @(posedge clock) begin
      reading_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            received++;
            if (pending_readings.size() == 0) begin
               $error("response transaction with nothing expected");
               errors++;
            end else begin
               exp_r = pending_readings.pop_front();
               if (rsp_temperature_tenths !== exp_r.temperature) begin
                  $error("temperature_tenths expected %0d got %0d",
                         exp_r.temperature, rsp_temperature_tenths);
                  errors++;
               end
               if (rsp_pressure_pa !== exp_r.pressure) begin
                  $error("pressure_pa expected %0d got %0d",
                         exp_r.pressure, rsp_pressure_pa);
                  errors++;
               end
               if (rsp_divide_error !== exp_r.div_err) begin
                  $error("divide_error expected %0d got %0d",
                         exp_r.div_err, rsp_divide_error);
                  errors++;
               end
            end
         end
         if (!hold_done && received == 250) begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
            rsp_ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      reading_type none;
      logic [63:0] wa, wb, wc;
      none = '0;
      // calibration all zero after reset: temperature divisor is zero
      rows.push_back('{0, CSR_COEFF_A, 0, 16'h0000, 24'h000000, 1, DIV_FAULT});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'hFFFF, 24'hFFFFFF, 1, DIV_FAULT});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'h8000, 24'h800000, 1, DIV_FAULT});
      rows.push_back('{1, CSR_COEFF_A, CAL_A, 0, 0, 0, none});
      rows.push_back('{1, CSR_COEFF_B, CAL_B, 0, 0, 0, none});
      rows.push_back('{1, CSR_COEFF_C, CAL_C, 0, 0, 0, none});
      rows.push_back('{1, CSR_OVERSAMPLING, 64'd0, 0, 0, 0, none});
      // textbook example point
      rows.push_back('{0, CSR_COEFF_A, 0, 16'd27898, 24'd23843 << 8, 1,
                       '{16'sd150, 21'sd69964, 1'b0}});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'h0000, 24'h000000, 0, none});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'hFFFF, 24'hFFFFFF, 0, none});
      rows.push_back('{1, CSR_OVERSAMPLING, 64'd3, 0, 0, 0, none});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'h0000, 24'hFFFFFF, 0, none});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'hFFFF, 24'h000000, 0, none});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'd27898, 24'h5D2300, 0, none});
      // ac4 zero makes the pressure divisor zero
      rows.push_back('{1, CSR_COEFF_A, {16'h0000, CAL_A[47:0]}, 0, 0, 0, none});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'd27898, 24'h5D2300, 1, DIV_FAULT});
      rows.push_back('{1, CSR_COEFF_A, CAL_A, 0, 0, 0, none});
      // md zero and ut equal to ac6 gives a zero temperature divisor
      rows.push_back('{1, CSR_COEFF_C, 64'h0000_DDF9, 0, 0, 0, none});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'd23153, 24'h123456, 1, DIV_FAULT});
      rows.push_back('{0, CSR_COEFF_A, 0, 16'd23154, 24'h654321, 0, none});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         if (row.is_csr) write_csr(row.idx, row.wdata);
         else send_sample(row.ut, row.up, row.typed, row.want);
      end

      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 4) begin
            send_idle_pct = 52;
            recv_idle_pct = 11;
         end else if (ph == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph % 5)
            0: begin
               wa = CAL_A ^ {8'($urandom_range(255)), 8'h00, 8'($urandom_range(255)),
                             8'h00, 16'h0000, 16'($urandom_range(255))};
               wb = CAL_B ^ {16'h0000, 16'($urandom_range(255)), 16'h0000,
                             16'($urandom_range(255))};
               wc = CAL_C ^ 64'($urandom_range(255));
            end
            1: begin
               wa = {$urandom, $urandom};
               wb = {$urandom, $urandom};
               wc = {32'd0, $urandom};
            end
            2: begin
               wa = '1;
               wb = '1;
               wc = 64'hFFFF_FFFF;
            end
            3: begin
               wa = 64'h8000_8000_8000_8000;
               wb = 64'h7FFF_7FFF_7FFF_7FFF;
               wc = 64'h8000_7FFF;
            end
            default: begin
               wa = 64'hFFFF_7FFF_7FFF_7FFF;
               wb = 64'h8000_8000_0001_FFFF;
               wc = 64'h7FFF_8000;
            end
         endcase
         write_csr(CSR_COEFF_A, wa);
         write_csr(CSR_COEFF_B, wb);
         write_csr(CSR_COEFF_C, wc);
         write_csr(CSR_OVERSAMPLING, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFFC |
                   64'(ph % 4));
         repeat (95) begin
            if ($urandom_range(99) < 70)
               send_sample(16'($urandom_range(40000, 20000)),
                           24'($urandom_range(24'hFFFFFF)), 0, none);
            else
               send_sample(16'($urandom_range(16'hFFFF)),
                           24'($urandom_range(24'hFFFFFF)), 0, none);
         end
      end

      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire
